@@ hdl/wide_text_to_unsigned_parser_top_macros.svh @@
// ----------------------------------------------------------------------------
// wide text to unsigned parser assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef WIDE_TEXT_TO_UNSIGNED_PARSER_TOP_MACROS_SVH
`define WIDE_TEXT_TO_UNSIGNED_PARSER_TOP_MACROS_SVH

// property that holds at every clock edge out of reset
`define WTTUP_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("wttup assertion failed");

// consequent must hold in the cycle after the antecedent
`define WTTUP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wttup assertion failed");

`endif

@@ hdl/wttup_pkg.sv @@
// ----------------------------------------------------------------------------
// wide text to unsigned parser package
// widths, character codes, parse phases and shared types
// ----------------------------------------------------------------------------
package wttup_pkg;

   localparam int CharWidth = 21;
   localparam int ValueWidth = 32;
   localparam int PosWidth = 11;
   localparam int BaseWidth = 6;
   localparam int DigitWidth = 7;

   localparam logic [PosWidth-1:0] MaxStringLength = 11'd1024;

   localparam logic [CharWidth-1:0] CharSpace = 21'h20;
   localparam logic [CharWidth-1:0] CharTab = 21'h09;
   localparam logic [CharWidth-1:0] CharPlus = 21'h2B;
   localparam logic [CharWidth-1:0] CharMinus = 21'h2D;
   localparam logic [CharWidth-1:0] CharZero = 21'h30;
   localparam logic [CharWidth-1:0] CharLowerX = 21'h78;
   localparam logic [CharWidth-1:0] CharUpperX = 21'h58;

   localparam logic [BaseWidth-1:0] BaseAuto = 6'd0;
   localparam logic [BaseWidth-1:0] BaseMin = 6'd2;
   localparam logic [BaseWidth-1:0] BaseOctal = 6'd8;
   localparam logic [BaseWidth-1:0] BaseDecimal = 6'd10;
   localparam logic [BaseWidth-1:0] BaseHex = 6'd16;
   localparam logic [BaseWidth-1:0] BaseMax = 6'd36;

   localparam logic [DigitWidth-1:0] NotDigit = 7'd99;

   typedef enum logic [6:0] {
      PhIdle     = 7'b0000001,
      PhLead     = 7'b0000010,
      PhSigned   = 7'b0000100,
      PhZero     = 7'b0001000,
      PhHexFirst = 7'b0010000,
      PhFirst    = 7'b0100000,
      PhDigits   = 7'b1000000
   } phase_type;

   typedef struct packed {
      phase_type                phase;
      logic                     minus;
      logic [BaseWidth-1:0]     base;
      logic [ValueWidth-1:0]    value;
      logic [PosWidth-1:0]      pos;
      logic [PosWidth-1:0]      dstart;
   } parse_state_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 string_start;
   } item_type;

   typedef struct packed {
      logic [ValueWidth-1:0] parsed_value;
      logic [PosWidth-1:0]   end_offset;
   } result_type;

   localparam parse_state_type ResetState = '{
      phase: PhIdle, minus: 1'b0, base: '0, value: '0, pos: '0, dstart: '0
   };

   function automatic logic [DigitWidth-1:0] digit_of(input logic [CharWidth-1:0] c);
      logic [DigitWidth-1:0] d;
      d = NotDigit;
      if (c inside {[21'h30:21'h39]}) begin
         d = DigitWidth'(c - 21'h30);
      end else if (c inside {[21'h61:21'h7A]}) begin
         d = DigitWidth'(c - 21'h61 + 21'd10);
      end else if (c inside {[21'h41:21'h5A]}) begin
         d = DigitWidth'(c - 21'h41 + 21'd10);
      end
      return d;
   endfunction

endpackage

@@ hdl/wttup_ifs.sv @@
// ----------------------------------------------------------------------------
// wide text to unsigned parser channels
// valid/ready channels for characters in and parsed numbers out
// ----------------------------------------------------------------------------
interface wttup_req_if;
   logic        valid;
   logic        ready;
   logic [20:0] char_code;
   logic        string_start;

   modport source (output valid, char_code, string_start, input ready);
   modport sink (input valid, char_code, string_start, output ready);
endinterface

interface wttup_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] parsed_value;
   logic [10:0] end_offset;

   modport source (output valid, parsed_value, end_offset, input ready);
   modport sink (input valid, parsed_value, end_offset, output ready);
endinterface

@@ hdl/wttup_in_stage.sv @@
// ----------------------------------------------------------------------------
// wttup input stage
// registers one character transfer ahead of the parse step
// ----------------------------------------------------------------------------
module wttup_in_stage (
   input  logic                clock,
   input  logic                reset,
   wttup_req_if.sink           req_if,
   output logic                item_valid,
   output wttup_pkg::item_type item,
   input  logic                item_ready
);
   import wttup_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   logic     load;

   assign req_if.ready = !valid_ff || item_ready;
   assign load = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.char_code <= req_if.char_code;
         item_ff.string_start <= req_if.string_start;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;
endmodule

@@ hdl/wttup_step.sv @@
// ----------------------------------------------------------------------------
// wttup parse step
// next parse state and optional result for one character
// ----------------------------------------------------------------------------
module wttup_step (
   input  wttup_pkg::item_type        item,
   input  logic [5:0]                 cfg_base,
   input  wttup_pkg::parse_state_type cur,
   output wttup_pkg::parse_state_type nxt,
   output logic                       emit,
   output wttup_pkg::result_type      result
);
   import wttup_pkg::*;

   parse_state_type         s;
   logic                    done;
   logic [CharWidth-1:0]    c;
   logic [DigitWidth-1:0]   d;
   logic                    digit_ok;
   logic [ValueWidth-1:0]   prod;
   logic [ValueWidth-1:0]   mac;
   logic [PosWidth-1:0]     pos_adv;
   result_type              res;

   assign c = item.char_code;
   assign d = digit_of(c);

   always_comb begin
      s = cur;
      done = 1'b0;
      emit = 1'b0;
      res = '0;
      digit_ok = 1'b0;
      prod = '0;
      mac = '0;
      pos_adv = '0;
      if (item.string_start) begin
         s.phase = PhLead;
         s.minus = 1'b0;
         s.value = '0;
         s.pos = '0;
         s.dstart = '0;
         s.base = cfg_base;
      end
      pos_adv = (s.pos < MaxStringLength) ? s.pos + 11'd1 : s.pos;
      if (s.phase == PhIdle) begin
         done = 1'b1;
      end
      // leading blanks and sign
      if (!done && s.phase == PhLead) begin
         if (c == CharSpace || c == CharTab) begin
            s.pos = pos_adv;
            done = 1'b1;
         end else begin
            s.phase = PhSigned;
            if (c == CharPlus || c == CharMinus) begin
               s.minus = (c == CharMinus);
               s.pos = pos_adv;
               done = 1'b1;
            end
         end
      end
      // possible radix prefix
      if (!done && s.phase == PhSigned) begin
         if (c == CharZero && (s.base == BaseAuto || s.base == BaseHex)) begin
            s.pos = pos_adv;
            s.dstart = pos_adv;
            s.phase = PhZero;
            done = 1'b1;
         end else begin
            if (s.base == BaseAuto) begin
               s.base = BaseDecimal;
            end
            s.phase = PhFirst;
         end
      end
      if (!done && s.phase == PhZero) begin
         if (c == CharLowerX || c == CharUpperX) begin
            s.pos = pos_adv;
            s.base = BaseHex;
            s.phase = PhHexFirst;
            done = 1'b1;
         end else begin
            if (s.base == BaseAuto) begin
               s.base = BaseOctal;
            end
            s.phase = PhDigits;
         end
      end
      // digit accumulate
      digit_ok = (s.base >= BaseMin) && (s.base <= BaseMax)
               && (d < {1'b0, s.base});
      prod = s.value * {{(ValueWidth-BaseWidth){1'b0}}, s.base};
      mac = prod + {{(ValueWidth-DigitWidth){1'b0}}, d};
      if (!done && s.phase == PhHexFirst) begin
         done = 1'b1;
         if (digit_ok) begin
            s.value = mac;
            s.pos = pos_adv;
            s.phase = PhDigits;
         end else begin
            emit = 1'b1;
            res.end_offset = s.dstart;
            s.phase = PhIdle;
         end
      end
      if (!done && s.phase == PhFirst) begin
         done = 1'b1;
         if (digit_ok) begin
            s.value = mac;
            s.pos = pos_adv;
            s.phase = PhDigits;
         end else begin
            emit = 1'b1;
            s.phase = PhIdle;
         end
      end
      if (!done && s.phase == PhDigits) begin
         if (digit_ok) begin
            s.value = mac;
            s.pos = pos_adv;
         end else begin
            emit = 1'b1;
            res.parsed_value = s.minus ? (~s.value + 32'd1) : s.value;
            res.end_offset = s.pos;
            s.phase = PhIdle;
         end
      end
   end

   assign nxt = s;
   assign result = res;
endmodule

@@ hdl/wttup_engine.sv @@
// ----------------------------------------------------------------------------
// wttup parse engine
// parse state, base register and result register around the parse step
// ----------------------------------------------------------------------------
`include "wide_text_to_unsigned_parser_top_macros.svh"

module wttup_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [wttup_pkg::BaseWidth-1:0] csr_wr_data,
   input  logic                item_valid,
   input  wttup_pkg::item_type item,
   output logic                item_ready,
   wttup_rsp_if.source         rsp_if
);
   import wttup_pkg::*;

   parse_state_type      state_ff;
   parse_state_type      state_in;
   logic [BaseWidth-1:0] base_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   result_type           step_result;
   logic                 step_emit;
   logic                 fire;

   wttup_step u_step (
      .item     (item),
      .cfg_base (base_ff),
      .cur      (state_ff),
      .nxt      (state_in),
      .emit     (step_emit),
      .result   (step_result)
   );

   // only a character that ends a number waits on a held result
   assign item_ready = !rsp_valid_ff || rsp_if.ready || !step_emit;
   assign fire = item_valid && item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ResetState;
         base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         if (fire) begin
            state_ff <= state_in;
         end
         if (fire && step_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.parsed_value = rsp_ff.parsed_value;
   assign rsp_if.end_offset = rsp_ff.end_offset;

   `WTTUP_ASSERT_ALWAYS(a_phase_onehot, $onehot(state_ff.phase))
   `WTTUP_ASSERT_ALWAYS(a_pos_bound, state_ff.pos <= MaxStringLength)
   `WTTUP_ASSERT_ALWAYS(a_dstart_le_pos, state_ff.dstart <= state_ff.pos)
   `WTTUP_ASSERT_NEXT(a_emit_to_idle, fire && step_emit,
      rsp_valid_ff && state_ff.phase == PhIdle)
endmodule

@@ hdl/wide_text_to_unsigned_parser_top.sv @@
// ----------------------------------------------------------------------------
// wide text to unsigned parser
// streaming strtoul-style number parser over wide characters
// ----------------------------------------------------------------------------
// req_if carries one 21-bit character per transfer; string_start marks the
// first character of a new string and restarts the parse, dropping any
// unfinished number. rsp_if gives one parsed_value/end_offset transfer when
// the first non-digit ends a number. csr_wr_data sets the radix (0 = auto)
// and is sampled at each string start; write it only while the block is idle.
// Throughput is one character per cycle unless a held result stalls it: one
// step of the parse state, with a single 32x6 multiply-add, sits between the
// input register and the result register. A character passes the input
// register, then its result is registered in the result register.
// When rsp_if stalls, the finished result is held and characters that do not
// end a number keep flowing; a character that would end another number waits
// in the input register and req_if stalls behind it.
// Reset clears the parse state to idle, the radix to 0 and drops any pending
// result; characters without string_start are ignored while idle.
// ----------------------------------------------------------------------------
module wide_text_to_unsigned_parser_top (
   input  logic                            clock,
   input  logic                            reset,
   wttup_req_if.sink                       req_if,
   wttup_rsp_if.source                     rsp_if,
   input  logic                            csr_wr_en,
   input  logic [wttup_pkg::BaseWidth-1:0] csr_wr_data
);
   import wttup_pkg::*;

   logic     item_valid;
   logic     item_ready;
   item_type item;

   wttup_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   wttup_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .item_ready  (item_ready),
      .rsp_if      (rsp_if)
   );
endmodule
